// File: design/hirc_pkg.sv
// ----------------------------------------------------------------------------
// hirc_pkg
// Shared types and constants for the IPv4 header receive check unit.
// ----------------------------------------------------------------------------
package hirc_pkg;

	typedef enum logic [2:0] {
		V_ACCEPT  = 3'd0,
		V_VERSION = 3'd1,
		V_TTL     = 3'd2,
		V_HDRLEN  = 3'd3,
		V_DEST    = 3'd4,
		V_CSUM    = 3'd5
	} verdict_t;

	// header fields gathered over one packet
	typedef struct packed {
		logic [3:0]  version;
		logic [3:0]  ihl;
		logic [7:0]  ttl;
		logic [31:0] dest;
		logic [15:0] sum;
	} hdr_fields_t;

	localparam logic [15:0] BYTE_SAT    = 16'hFFFF;
	localparam logic [15:0] SUM_GOOD    = 16'hFFFF;
	localparam logic [15:0] TTL_IDX     = 16'd8;
	localparam logic [15:0] DEST_FIRST  = 16'd16;
	localparam logic [15:0] DEST_LAST   = 16'd19;
	localparam logic [3:0]  IPV4_VER    = 4'd4;
	localparam logic [3:0]  IHL_MIN     = 4'd5;
	localparam logic        REG_LOCAL_ADDR = 1'b0;

endpackage

// File: design/ipv4_header_receive_check_unit.sv
// ----------------------------------------------------------------------------
// ipv4_header_receive_check_unit
// Byte-stream IPv4 header checker giving one verdict per packet.
// ----------------------------------------------------------------------------
// Takes one packet byte per beat on the slave stream, tlast on the final byte,
// and returns one result beat per packet on the master stream once the final
// byte is processed. Sustained rate is one byte per clock unless back-pressure
// holds a final byte: each beat passes an input register, then field capture,
// 16-bit end-around-carry add and the verdict compare, into the result
// register. The result register loads as the final byte leaves the input
// register. A beat without tlast gives no result; the only back-pressure comes
// from a waiting result when another final byte reaches the processing stage.
// The header sum covers only the first IHL*4 bytes; an odd trailing header byte
// of a short packet counts as a high byte. local_address sits at byte address 0.
// ----------------------------------------------------------------------------
module ipv4_header_receive_check_unit (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	input  logic        s_tlast,    // last_byte
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [2:0] verdict, [18:3] packet_bytes, [23:19] zero
	// APB register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration
	logic [31:0] local_addr_q;

	// input register
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        go_s1;

	// result register
	logic               out_valid_q;
	hirc_pkg::verdict_t verdict_q;
	logic [15:0]        bytes_q;

	hirc_pkg::hdr_fields_t fields_nxt;
	logic [15:0]           count_nxt;
	hirc_pkg::verdict_t    verdict_c;

	// --- APB: always ready, register decoded on paddr[2] ---
	assign pready = 1'b1;
	assign prdata = (paddr[2] == hirc_pkg::REG_LOCAL_ADDR) ? local_addr_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == hirc_pkg::REG_LOCAL_ADDR) begin
			local_addr_q <= pwdata;
		end
	end

	// --- input register; a final byte waits only if the result slot stays full ---
	assign go_s1    = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// --- per-packet state and checks ---
	hirc_fields u_fields (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (go_s1),
		.data_byte  (data_s1),
		.last_byte  (last_s1),
		.fields_nxt (fields_nxt),
		.count_nxt  (count_nxt)
	);

	hirc_verdict u_verdict (
		.fields        (fields_nxt),
		.local_address (local_addr_q),
		.verdict       (verdict_c)
	);

	// --- result register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			verdict_q <= verdict_c;
			bytes_q   <= count_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, bytes_q, verdict_q};

	// --- checks ---
	// a result only appears after a final byte went through processing
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(go_s1 && last_s1))
		else $error("result raised without a processed final byte");

	// a held beat in the input register is not dropped or altered
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go_s1) |=> (valid_s1 && $stable(data_s1) && $stable(last_s1)))
		else $error("stalled input beat lost");

	// an accepted packet must have reached the TTL byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q == hirc_pkg::V_ACCEPT) |-> (bytes_q >= 16'd9))
		else $error("accept verdict on a packet too short");

	// a new result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !(go_s1 && last_s1))
		else $error("pending result overwritten");

endmodule

// File: design/hirc_fields.sv
// ----------------------------------------------------------------------------
// hirc_fields
// Per-packet state: byte count, field capture and ones'-complement header sum.
// ----------------------------------------------------------------------------
module hirc_fields (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,       // process one beat
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output hirc_pkg::hdr_fields_t fields_nxt, // fields including this beat
	output logic [15:0]          count_nxt
);

	logic [15:0] count_q;
	logic [7:0]  hold_q;
	hirc_pkg::hdr_fields_t fields_q;

	logic        sat;
	logic        in_hdr;
	logic        add_en;
	logic [5:0]  hdr_bytes;
	logic [15:0] word;
	logic [16:0] sum_raw;
	logic [15:0] sum_add;
	logic [7:0]  hold_nxt;

	always_comb begin
		sat = (count_q == hirc_pkg::BYTE_SAT);
		fields_nxt = fields_q;
		if (!sat && count_q == 16'd0) begin
			fields_nxt.version = data_byte[7:4];
			fields_nxt.ihl     = data_byte[3:0];
		end
		if (!sat && count_q == hirc_pkg::TTL_IDX) begin
			fields_nxt.ttl = data_byte;
		end
		if (!sat && count_q >= hirc_pkg::DEST_FIRST && count_q <= hirc_pkg::DEST_LAST) begin
			fields_nxt.dest = {fields_q.dest[23:0], data_byte};
		end
		hdr_bytes = {fields_nxt.ihl, 2'b00};
		in_hdr    = !sat && (count_q < {10'd0, hdr_bytes});
		// odd index pairs with the held byte; a final even-index byte stands alone as high byte
		add_en    = in_hdr && (count_q[0] || last_byte);
		word      = count_q[0] ? {hold_q, data_byte} : {data_byte, 8'h00};
		sum_raw   = {1'b0, fields_q.sum} + {1'b0, word};
		sum_add   = sum_raw[15:0] + {15'd0, sum_raw[16]};
		if (add_en) begin
			fields_nxt.sum = sum_add;
		end
		hold_nxt  = (in_hdr && !count_q[0]) ? data_byte : hold_q;
		count_nxt = sat ? count_q : count_q + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			hold_q   <= '0;
			fields_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				count_q  <= '0;
				hold_q   <= '0;
				fields_q <= '0;
			end else begin
				count_q  <= count_nxt;
				hold_q   <= hold_nxt;
				fields_q <= fields_nxt;
			end
		end
	end

endmodule

// File: design/hirc_verdict.sv
// ----------------------------------------------------------------------------
// hirc_verdict
// Priority check of the gathered header fields.
// ----------------------------------------------------------------------------
module hirc_verdict (
	input  hirc_pkg::hdr_fields_t fields,
	input  logic [31:0]           local_address,
	output hirc_pkg::verdict_t    verdict
);

	always_comb begin
		if (fields.version != hirc_pkg::IPV4_VER) begin
			verdict = hirc_pkg::V_VERSION;
		end else if (fields.ttl == 8'd0) begin
			verdict = hirc_pkg::V_TTL;
		end else if (fields.ihl < hirc_pkg::IHL_MIN) begin
			verdict = hirc_pkg::V_HDRLEN;
		end else if (fields.dest != local_address) begin
			verdict = hirc_pkg::V_DEST;
		end else if (fields.sum != hirc_pkg::SUM_GOOD) begin
			verdict = hirc_pkg::V_CSUM;
		end else begin
			verdict = hirc_pkg::V_ACCEPT;
		end
	end

endmodule

// File: sim/ipv4_header_receive_check_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_header_receive_check_unit_tb
// Self-checking bench for the byte-stream IPv4 header checker.
// ----------------------------------------------------------------------------
// Packet bytes wait in a queue that the stimulus block fills. A clocked driver
// offers them on the slave stream with random gaps. Each accepted byte feeds a
// behavioural copy of the checker, which queues the verdict beat that a final
// byte should produce. A clocked monitor takes result beats with random stalls
// and compares verdict and byte count against the oldest queued verdict. The
// local address is rewritten over APB between phases, only while idle.
// ----------------------------------------------------------------------------
module ipv4_header_receive_check_unit_tb;

	localparam logic [2:0] ADDR_LOCAL_ADDR = {hirc_pkg::REG_LOCAL_ADDR, 2'b00};

	typedef struct {
		logic [7:0] data;
		logic       last;
	} byte_beat_t;

	typedef struct {
		hirc_pkg::verdict_t verdict;
		logic [15:0]        pkt_len;
	} verdict_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;        // [7:0] data_byte
	logic        s_tlast = 1'b0;      // last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;             // [2:0] verdict, [18:3] packet_bytes, [23:19] zero
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	ipv4_header_receive_check_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// bytes still to go out, verdicts still to come back
	byte_beat_t    pending_bytes[$];
	verdict_beat_t expected_verdicts[$];

	// gap limits per phase; rx_halt forces a long receiver hold-off
	int tx_gap_max = 12;
	int rx_gap_max = 12;
	logic rx_halt = 1'b0;
	int tx_wait;
	int rx_wait;

	int fail_count = 0;
	int bytes_in = 0;
	int pkts_in = 0;
	int rand_bytes = 0;
	int rand_pkts = 0;
	int verdicts_seen[8];

	// shadow of the checker: register plus per-packet capture
	logic [31:0] local_ip = '0;
	logic [15:0] cnt_bytes = '0;
	logic [15:0] hdr_csum = '0;
	logic [7:0]  hi_hold = '0;
	logic [3:0]  f_ver = '0;
	logic [3:0]  f_ihl = '0;
	logic [7:0]  f_ttl = '0;
	logic [31:0] f_dest = '0;

	// 16-bit ones'-complement add, carry folded back in
	function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] w);
		logic [16:0] s;
		s = {1'b0, acc} + {1'b0, w};
		return s[15:0] + 16'(s[16]);
	endfunction

	function automatic void ingest_byte(input logic [7:0] b, input logic last);
		logic [15:0]   idx;
		int            hdr_len;
		verdict_beat_t res;
		idx = cnt_bytes;
		// count pinned at its limit: nothing more is captured or summed
		if (idx != hirc_pkg::BYTE_SAT) begin
			if (idx == 16'd0) begin
				f_ver = b[7:4];
				f_ihl = b[3:0];
			end else if (idx == hirc_pkg::TTL_IDX) begin
				f_ttl = b;
			end else if (idx >= hirc_pkg::DEST_FIRST && idx <= hirc_pkg::DEST_LAST) begin
				f_dest = {f_dest[23:0], b};
			end
			// IHL is known from byte 0 onwards, so byte 0 itself is summed if IHL != 0
			hdr_len = f_ihl * 4;
			if (idx < hdr_len) begin
				if (!idx[0])
					hi_hold = b;
				else
					hdr_csum = ones_add(hdr_csum, {hi_hold, b});
			end
			cnt_bytes = idx + 16'd1;
		end
		if (last) begin
			hdr_len = f_ihl * 4;
			// header cut short on an odd byte: lone byte goes in as high half
			if (cnt_bytes < hdr_len && cnt_bytes[0])
				hdr_csum = ones_add(hdr_csum, {hi_hold, 8'h00});
			if (f_ver != hirc_pkg::IPV4_VER)
				res.verdict = hirc_pkg::V_VERSION;
			else if (f_ttl == 8'd0)
				res.verdict = hirc_pkg::V_TTL;
			else if (f_ihl < hirc_pkg::IHL_MIN)
				res.verdict = hirc_pkg::V_HDRLEN;
			else if (f_dest != local_ip)
				res.verdict = hirc_pkg::V_DEST;
			else if (hdr_csum != hirc_pkg::SUM_GOOD)
				res.verdict = hirc_pkg::V_CSUM;
			else
				res.verdict = hirc_pkg::V_ACCEPT;
			res.pkt_len = cnt_bytes;
			expected_verdicts.push_back(res);
			cnt_bytes = '0;
			hdr_csum = '0;
			hi_hold = '0;
			f_ver = '0;
			f_ihl = '0;
			f_ttl = '0;
			f_dest = '0;
		end
	endfunction

	// Builds one packet of len bytes. With fix_sum and at least 12 header bytes sent,
	// the checksum field is set so that the received part of the header (odd tail zero-padded) sums to 0xFFFF.
	task automatic queue_packet(input logic [3:0] ver, input logic [3:0] ihl,
			input logic [7:0] ttl, input logic [31:0] dst, input int len, input bit fix_sum);
		logic [7:0]  pkt[];
		logic [15:0] acc;
		int          span;
		pkt = new[len];
		foreach (pkt[i])
			pkt[i] = 8'($urandom);
		pkt[0] = {ver, ihl};
		if (len > 8)
			pkt[8] = ttl;
		for (int i = 0; i < 4; i++) begin
			if (len > 16 + i)
				pkt[16 + i] = dst[31 - 8 * i -: 8];
		end
		span = (len < ihl * 4) ? len : ihl * 4;
		if (fix_sum && span >= 12) begin
			pkt[10] = 8'h00;
			pkt[11] = 8'h00;
			acc = '0;
			for (int i = 0; i < span; i += 2)
				acc = ones_add(acc, {pkt[i], (i + 1 < span) ? pkt[i + 1] : 8'h00});
			{pkt[10], pkt[11]} = ~acc;
		end
		foreach (pkt[i])
			pending_bytes.push_back(byte_beat_t'{pkt[i], i == len - 1});
	endtask

	// Mostly well-formed headers with random content; some cut short, the rest
	// broken fields and noise.
	task automatic queue_random_packet(output int len);
		int kind;
		int ihl;
		kind = $urandom_range(0, 99);
		ihl = $urandom_range(0, 1) ? 5 : $urandom_range(5, 15);
		if (kind < 60) begin
			len = ihl * 4 + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 24) : 0);
			queue_packet(hirc_pkg::IPV4_VER, 4'(ihl),
				($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(1, 255)),
				($urandom_range(0, 9) == 0) ? $urandom : local_ip,
				len, $urandom_range(0, 9) != 0);
		end else if (kind < 75) begin
			len = $urandom_range(1, ihl * 4 - 1);
			queue_packet(hirc_pkg::IPV4_VER, 4'(ihl), 8'($urandom_range(1, 255)), local_ip,
				len, 1'b1);
		end else begin
			len = $urandom_range(1, 64);
			queue_packet($urandom_range(0, 1) ? hirc_pkg::IPV4_VER : 4'($urandom),
				4'($urandom),
				($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom),
				$urandom_range(0, 1) ? local_ip : $urandom,
				len, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic random_run(input int n_bytes);
		int got;
		int len;
		got = 0;
		while (got < n_bytes) begin
			queue_random_packet(len);
			got += len;
			rand_bytes += len;
			rand_pkts++;
		end
	endtask

	// returns at a falling edge once everything sent has been answered
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || s_tvalid || expected_verdicts.size() != 0);
		// a non-final beat may still be in the pipe
		repeat (4) @(negedge clk);
	endtask

	task automatic write_local_addr(input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_LOCAL_ADDR;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		local_ip = val;
		@(negedge clk);
	endtask

	// sender: one beat in flight, held until taken, then a random gap
	always @(posedge clk or negedge arst_n) begin : tx_drive
		byte_beat_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			tx_wait <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				ingest_byte(s_tdata, s_tlast);
				bytes_in++;
				if (s_tlast)
					pkts_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_wait != 0) begin
					s_tvalid <= 1'b0;
					tx_wait <= tx_wait - 1;
				end else if (pending_bytes.size() != 0) begin
					nxt = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nxt.data;
					s_tlast <= nxt.last;
					tx_wait <= $urandom_range(0, tx_gap_max);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result beat, then stalls a random number of cycles
	always @(posedge clk or negedge arst_n) begin : rx_check
		int            w;
		verdict_beat_t exp_v;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait <= 0;
		end else begin
			w = rx_wait;
			if (m_tvalid && m_tready) begin
				verdicts_seen[m_tdata[2:0]]++;
				if (expected_verdicts.size() == 0) begin
					$error("result beat with nothing expected: verdict %0d, packet_bytes %0d",
						m_tdata[2:0], m_tdata[18:3]);
					fail_count++;
				end else begin
					exp_v = expected_verdicts.pop_front();
					if (m_tdata[2:0] != exp_v.verdict) begin
						$error("verdict: expected %0d, got %0d", exp_v.verdict, m_tdata[2:0]);
						fail_count++;
					end
					if (m_tdata[18:3] != exp_v.pkt_len) begin
						$error("packet_bytes: expected %0d, got %0d", exp_v.pkt_len,
							m_tdata[18:3]);
						fail_count++;
					end
				end
				w = $urandom_range(0, rx_gap_max);
			end else if (w != 0) begin
				w--;
			end
			rx_wait <= w;
			m_tready <= (w == 0) && !rx_halt;
		end
	end

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: byte extremes as one-byte packets, TTL zero, IHL zero
		write_local_addr(32'hC0A8_0001);
		queue_packet(4'h0, 4'h0, 8'h00, 32'h0, 1, 1'b0);
		queue_packet(4'hF, 4'hF, 8'hFF, 32'h0, 1, 1'b0);
		queue_packet(hirc_pkg::IPV4_VER, hirc_pkg::IHL_MIN, 8'h00, 32'h0, 9, 1'b0);
		queue_packet(hirc_pkg::IPV4_VER, 4'h0, 8'hFF, 32'h0, 9, 1'b0);
		wait_idle();

		// random address, idling on both sides
		write_local_addr($urandom);
		random_run(300);
		wait_idle();

		// all-ones address; receiver holds off while short packets pile up
		write_local_addr(32'hFFFF_FFFF);
		tx_gap_max = 0;
		rx_gap_max = 0;
		rx_halt = 1'b1;
		for (int i = 0; i < 30; i++) begin
			int blen;
			blen = $urandom_range(1, 3);
			queue_packet(4'($urandom), 4'($urandom), 8'($urandom), $urandom, blen, 1'b0);
			rand_bytes += blen;
			rand_pkts++;
		end
		repeat (250) @(negedge clk);
		rx_halt = 1'b0;
		random_run(200);
		// sender pauses here until every verdict is back
		wait_idle();
		tx_gap_max = 5;
		rx_gap_max = 5;
		random_run(100);
		wait_idle();

		// zero address: truncated headers leave dest at zero and can pass
		write_local_addr(32'h0);
		tx_gap_max = 12;
		rx_gap_max = 0;
		random_run(250);
		wait_idle();

		// sender back to back, receiver idling
		write_local_addr($urandom);
		tx_gap_max = 0;
		rx_gap_max = 12;
		random_run(50);
		wait_idle();

		write_local_addr($urandom);
		tx_gap_max = 12;
		rx_gap_max = 12;
		random_run(1050 - rand_bytes);
		while (rand_pkts < 60)
			random_run(1);
		wait_idle();
		repeat (10) @(negedge clk);

		$display("%0d bytes in %0d packets sent, with stalls on both sides and one long hold-off",
			bytes_in, pkts_in);
		$display("verdicts: accept %0d, version %0d, ttl %0d, hdrlen %0d, dest %0d, csum %0d",
			verdicts_seen[hirc_pkg::V_ACCEPT], verdicts_seen[hirc_pkg::V_VERSION],
			verdicts_seen[hirc_pkg::V_TTL], verdicts_seen[hirc_pkg::V_HDRLEN],
			verdicts_seen[hirc_pkg::V_DEST], verdicts_seen[hirc_pkg::V_CSUM]);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
